[sv/arp_pkg.sv]
// ----------------------------------------------------------------------------
// arp_pkg - shared types and constants of the ATLAS request picker
// Sizes of the request fields, the stream word layouts and the candidate
// record that is compared against the running best.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int unsigned BufferDepth = 64;
  localparam int unsigned TimeBits    = 32;
  localparam int unsigned RankBits    = 8;
  localparam int unsigned ThrBits     = 32;
  localparam int unsigned IdxBits     = $clog2(BufferDepth);

  // age compare runs at the wider of the two
  localparam int unsigned AgeBits = (TimeBits > ThrBits) ? TimeBits : ThrBits;

  localparam logic [ThrBits-1:0] ThrReset = ThrBits'(100000);

  // slave tdata: decision_time | arrival_time | thread_rank, rounded to bytes
  localparam int unsigned SDataBits = ((2 * TimeBits + RankBits + 7) / 8) * 8;
  // master tdata: winner_index | winner_arrival, rounded to bytes
  localparam int unsigned MDataBits = ((IdxBits + TimeBits + 7) / 8) * 8;

  typedef struct packed {
    logic                starving;
    logic [RankBits-1:0] rank;
    logic                ready;
    logic [TimeBits-1:0] arrival;
  } cand_t;

endpackage

[sv/atlas_request_picker_top.sv]
// ----------------------------------------------------------------------------
// atlas_request_picker_top - ATLAS-style DRAM request picker
// Folds a set of requests, one per beat, into a single winner and reports
// its index and arrival time on the last request of the set.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata, tuser = is_ready,
//                                        tlast = last_request
//  m_axis    out  tvalid/tready          tdata = winner_index, winner_arrival
//  cfg       in   cfg_we_i (no stall)    cfg_wdata_i = starvation_threshold
//
//  One request per cycle sustained unless a last request is stalled. A
//  request is held in the input register, then is folded into the running
//  best; the winner lands in the output register at the same edge that
//  folds the last request of a set. Only the last request of a set waits
//  on a full, stalled output register; other requests keep flowing. Reset
//  clears the set position, valids and restores the threshold to 100000.
//
module atlas_request_picker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [arp_pkg::ThrBits-1:0]   cfg_wdata_i,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] decision_time, [63:32] arrival_time, [71:64] thread_rank
  input  logic [arp_pkg::SDataBits-1:0] s_axis_tdata,
  // [0] is_ready
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tlast,
  // winner stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [5:0] winner_index, [37:6] winner_arrival, [39:38] zero
  output logic [arp_pkg::MDataBits-1:0] m_axis_tdata
);
  import arp_pkg::*;

  localparam logic [IdxBits-1:0] PosMax = IdxBits'(BufferDepth - 1);

  // threshold register
  logic [ThrBits-1:0] thr_q;

  // input register
  logic                 s1_valid_q, s1_valid_d;
  logic [SDataBits-1:0] s1_data_q;
  logic                 s1_ready_q;
  logic                 s1_last_q;

  // running best of the open set
  logic [TimeBits-1:0] held_q, held_d;
  logic [IdxBits-1:0]  pos_q, pos_d;
  logic [IdxBits-1:0]  best_idx_q, best_idx_d;
  cand_t               best_q, best_d;

  // output register
  logic                 m_valid_q, m_valid_d;
  logic [MDataBits-1:0] m_data_q, m_data_d;

  logic                s_accept;
  logic                out_free;
  logic                s1_go;
  logic                first;
  logic [TimeBits-1:0] now;
  cand_t               cand;
  logic                beats;
  logic                take;

  // decode the held request
  logic [TimeBits-1:0] s1_decision;
  logic [TimeBits-1:0] s1_arrival;
  logic [RankBits-1:0] s1_rank;

  assign s1_decision = s1_data_q[TimeBits-1:0];
  assign s1_arrival  = s1_data_q[2*TimeBits-1:TimeBits];
  assign s1_rank     = s1_data_q[2*TimeBits+RankBits-1:2*TimeBits];

  // handshake: the held request leaves unless it is a last one facing a full
  // output register
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s1_go         = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // first request of a set latches its own decision time
  assign first = (pos_q == '0);
  assign now   = first ? s1_decision : held_q;

  arp_challenger u_challenger (
    .now_i     (now),
    .thr_i     (thr_q),
    .arrival_i (s1_arrival),
    .rank_i    (s1_rank),
    .ready_i   (s1_ready_q),
    .best_i    (best_q),
    .cand_o    (cand),
    .wins_o    (beats)
  );

  assign take = first || beats;

  always_comb begin
    s1_valid_d = s_accept || (s1_valid_q && !s1_go);
    held_d     = held_q;
    pos_d      = pos_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    if (s1_go) begin
      held_d = now;
      if (take) begin
        best_idx_d = pos_q;
        best_d     = cand;
      end
      if (s1_last_q) begin
        pos_d     = '0;
        m_valid_d = 1'b1;
        m_data_d  = MDataBits'({best_d.arrival, best_idx_d});
      end else if (pos_q != PosMax) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= ThrReset;
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      pos_q      <= '0;
      held_q     <= '0;
      best_idx_q <= '0;
      best_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
      pos_q      <= pos_d;
      held_q     <= held_d;
      best_idx_q <= best_idx_d;
      best_q     <= best_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_data_q  <= s_axis_tdata;
      s1_ready_q <= s_axis_tuser;
      s1_last_q  <= s_axis_tlast;
    end
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // the held request can only stall as a last request behind a blocked result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s_axis_tready |-> s1_last_q && m_valid_q && !m_axis_tready)
    else $error("request stage stalled without a blocked result");

  // a folded last request reopens the set
  a_set_reopen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_last_q |=> pos_q == '0)
    else $error("position not cleared after last request");

  // a result only appears after a last request is folded
  a_result_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s1_go && s1_last_q))
    else $error("result without a last request");

endmodule

[sv/arp_challenger.sv]
// ----------------------------------------------------------------------------
// arp_challenger - one fold step of the request picker
// Derives the starving flag of a request and decides whether it beats the
// incumbent best. Ties keep the incumbent.
// ----------------------------------------------------------------------------
module arp_challenger (
  input  logic [arp_pkg::TimeBits-1:0] now_i,
  input  logic [arp_pkg::ThrBits-1:0]  thr_i,
  input  logic [arp_pkg::TimeBits-1:0] arrival_i,
  input  logic [arp_pkg::RankBits-1:0] rank_i,
  input  logic                         ready_i,
  input  arp_pkg::cand_t               best_i,
  output arp_pkg::cand_t               cand_o,
  output logic                         wins_o
);
  import arp_pkg::*;

  logic [TimeBits-1:0] age;

  // age wraps modulo the time width
  assign age = now_i - arrival_i;

  always_comb begin
    cand_o.starving = AgeBits'(age) > AgeBits'(thr_i);
    cand_o.rank     = rank_i;
    cand_o.ready    = ready_i;
    cand_o.arrival  = arrival_i;
  end

  always_comb begin
    if (cand_o.starving != best_i.starving) begin
      wins_o = cand_o.starving;
    end else if (cand_o.rank != best_i.rank) begin
      wins_o = cand_o.rank < best_i.rank;
    end else if (cand_o.ready != best_i.ready) begin
      wins_o = cand_o.ready;
    end else begin
      wins_o = cand_o.arrival < best_i.arrival;
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for atlas_request_picker_top
// Streams sets of DRAM requests into the picker, folds each accepted request
// into a local copy of the picker state and checks every winner it reports.
// Runs several starvation thresholds, random gaps on both streams, one long
// output stall and sets both shorter and longer than the buffer depth.
// ----------------------------------------------------------------------------
module tb;
  import arp_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;  // quiet cycles before giving up
  localparam int unsigned DrainCycles   = 6;     // settle time after the block goes idle
  localparam int unsigned MaxGap        = 4;
  localparam int unsigned HoldCycles    = 150;   // long receiver stall

  // one request as the sender sees it
  typedef struct packed {
    logic [TimeBits-1:0] decision;
    logic [TimeBits-1:0] arrival;
    logic [RankBits-1:0] rank;
    logic                ready;
    logic                last;
  } request_t;

  // one winner as reported on m_axis
  typedef struct packed {
    logic [IdxBits-1:0]  index;
    logic [TimeBits-1:0] arrival;
  } winner_t;

  // all block inputs start at known values
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [ThrBits-1:0]   cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic [SDataBits-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tready = 1'b0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [MDataBits-1:0] m_axis_tdata;

  atlas_request_picker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Picker state as the bench tracks it
  // --------------------------------------------------------------------------
  logic [ThrBits-1:0]  threshold_m  = ThrReset;
  logic [TimeBits-1:0] held_time_m  = '0;
  cand_t               best_m       = '0;
  logic [IdxBits-1:0]  best_index_m = '0;
  logic [IdxBits-1:0]  position_m   = '0;   // zero: next request opens a set

  request_t    pending_q[$];   // requests not yet offered
  winner_t     winner_q[$];    // winners still owed by the block
  request_t    cur_req = '0;   // request currently on s_axis

  int unsigned errors        = 0;
  int unsigned requests_seen = 0;
  int unsigned winners_seen  = 0;
  int unsigned longest_set   = 0;
  int unsigned gap_left      = 0;
  int unsigned stall_left    = 0;
  logic        no_idle       = 1'b0;   // back-to-back on both streams
  logic        pressure_go   = 1'b0;
  logic        hold_rx       = 1'b0;

  // age wraps at TimeBits; strictly greater than the threshold starves
  function automatic logic starving(input logic [TimeBits-1:0] arrival);
    logic [TimeBits-1:0] age;
    age = held_time_m - arrival;
    return age > threshold_m;
  endfunction

  // rule order: starving, lower rank, ready, older; a tie keeps the incumbent
  function automatic logic beats_best(input cand_t c);
    if (c.starving != best_m.starving) return c.starving;
    if (c.rank != best_m.rank)         return c.rank < best_m.rank;
    if (c.ready != best_m.ready)       return c.ready;
    return c.arrival < best_m.arrival;
  endfunction

  function automatic void fold_request(input request_t r);
    cand_t c;
    if (position_m == '0) held_time_m = r.decision;
    c.starving = starving(r.arrival);
    c.rank     = r.rank;
    c.ready    = r.ready;
    c.arrival  = r.arrival;
    if (position_m == '0 || beats_best(c)) begin
      best_m       = c;
      best_index_m = position_m;
    end
    // position saturates, later requests share the top index
    if (position_m != IdxBits'(BufferDepth - 1)) position_m++;
    if (r.last) begin
      winner_q.push_back('{index: best_index_m, arrival: best_m.arrival});
      position_m = '0;
    end
  endfunction

  function automatic void note_mismatch(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("ERROR winner %0d: %s expected 0x%0h, got 0x%0h",
               winners_seen, field, want, got);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: one request per handshake, random gap after each
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic fire;
    fire = s_axis_tvalid && s_axis_tready;
    if (fire) begin
      fold_request(cur_req);
      requests_seen++;
      gap_left = no_idle ? 0 : $urandom_range(0, MaxGap);
    end
    if (rst_ni && (fire || !s_axis_tvalid)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_req = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= SDataBits'({cur_req.rank, cur_req.arrival, cur_req.decision});
        s_axis_tuser  <= cur_req.ready;
        s_axis_tlast  <= cur_req.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Winner monitor: checks against the oldest owed winner, random stalls
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    winner_t got;
    winner_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.index   = m_axis_tdata[IdxBits-1:0];
      got.arrival = m_axis_tdata[IdxBits +: TimeBits];
      winners_seen++;
      if (winner_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR winner %0d: none expected, got index %0d arrival 0x%0h",
                   winners_seen, got.index, got.arrival);
      end else begin
        want = winner_q.pop_front();
        if (got.index !== want.index)
          note_mismatch("winner_index", 64'(want.index), 64'(got.index));
        if (got.arrival !== want.arrival)
          note_mismatch("winner_arrival", 64'(want.arrival), 64'(got.arrival));
      end
      stall_left = no_idle ? 0 : $urandom_range(0, MaxGap);
    end
    if (!rst_ni || hold_rx) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // long receiver hold-off: output register fills and s_axis backs up
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // watchdog on cycles with no handshake on either stream
  always @(posedge clk_i) begin
    int unsigned quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WatchdogLimit) begin
      $display("Watchdog: no handshake for %0d cycles, %0d winners owed",
               WatchdogLimit, winner_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_request(input logic [TimeBits-1:0] decision,
                             input logic [TimeBits-1:0] arrival,
                             input logic [RankBits-1:0] rank,
                             input logic ready, input logic last);
    pending_q.push_back('{decision: decision, arrival: arrival, rank: rank,
                          ready: ready, last: last});
  endtask

  // ages cluster around the threshold so both sides of the starve edge show up
  function automatic logic [TimeBits-1:0] pick_age();
    case ($urandom_range(0, 5))
      0:       return TimeBits'($urandom_range(0, 1000));
      1, 2:    return TimeBits'(threshold_m + TimeBits'($urandom_range(0, 4)) - 2);
      3:       return '0;
      default: return TimeBits'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(1, 4);
    if (r < 18) return $urandom_range(5, 16);
    return $urandom_range(17, 40);
  endfunction

  task automatic add_random_set(input int unsigned len);
    logic [TimeBits-1:0] now;
    logic [TimeBits-1:0] prev;
    request_t            r;
    logic                noisy;
    noisy = ($urandom_range(0, 7) == 0);
    now   = $urandom;
    prev  = now;
    for (int unsigned i = 0; i < len; i++) begin
      // only the opening request's decision time matters
      r.decision = (i == 0) ? now : TimeBits'($urandom);
      if (noisy)
        r.arrival = $urandom;
      else if (i > 0 && $urandom_range(0, 5) == 0)
        r.arrival = prev;                        // arrival tie
      else
        r.arrival = now - pick_age();
      prev    = r.arrival;
      // narrow ranks force ties down to the ready and age rules
      r.rank  = (noisy || $urandom_range(0, 3) == 0) ? RankBits'($urandom_range(0, 255))
                                                     : RankBits'($urandom_range(0, 3));
      r.ready = 1'($urandom_range(0, 1));
      r.last  = (i == len - 1);
      pending_q.push_back(r);
    end
    if (len > longest_set) longest_set = len;
  endtask

  // block idle: nothing pending, nothing on s_axis, nothing owed
  task automatic wait_idle();
    while (pending_q.size() != 0 || s_axis_tvalid || winner_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThrBits-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    threshold_m = value;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [ThrBits-1:0] value, input int unsigned target,
                           input logic calm, input logic squeeze);
    int unsigned added;
    wait_idle();
    write_threshold(value);
    no_idle = calm;
    if (squeeze) pressure_go = 1'b1;
    added = 0;
    while (added < target) begin
      if (squeeze) begin
        add_random_set(1);       // one winner per request fills the output fast
        added++;
      end else begin
        add_random_set(pick_len());
        added = pending_q.size();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, threshold still at its reset value
    // single-request sets at the field extremes
    add_request('0, '0, '0, 1'b0, 1'b1);
    add_request('1, '1, '1, 1'b1, 1'b1);
    // walk every rule; decision fields after the first must be ignored
    add_request(32'd1000000, 32'd999990, 8'd5,   1'b0, 1'b0);
    add_request('1,          32'd999995, 8'd5,   1'b0, 1'b0);  // newer, loses
    add_request('0,          32'd999990, 8'd5,   1'b0, 1'b0);  // full tie, incumbent
    add_request('0,          32'd999999, 8'd5,   1'b1, 1'b0);  // ready wins
    add_request('0,          32'd999000, 8'd5,   1'b0, 1'b0);  // not ready, loses
    add_request('0,          32'd999999, 8'd3,   1'b0, 1'b0);  // lower rank wins
    add_request('0,          32'd998000, 8'd3,   1'b0, 1'b0);  // older wins
    add_request('0,          32'd0,      8'd255, 1'b0, 1'b0);  // starving wins
    add_request('0,          32'd900000, 8'd0,   1'b1, 1'b0);  // age at threshold only
    add_request('0,          32'd899999, 8'd200, 1'b0, 1'b0);  // starving, lower rank
    add_request('0,          32'd5,      8'd200, 1'b0, 1'b1);  // starving, older
    // decision time near zero, arrivals from before the wrap and from the future
    add_request(32'd5,  32'hFFFF_FFF0, 8'd10,  1'b1, 1'b0);
    add_request('1,     32'hFFFF_0000, 8'd10,  1'b1, 1'b0);
    add_request('0,     32'h8000_0000, 8'd255, 1'b0, 1'b1);
    longest_set = 11;

    // random part over several thresholds
    run_phase('0,          40, 1'b0, 1'b0);   // every nonzero age starves
    run_phase('1,          40, 1'b0, 1'b0);   // nothing starves
    run_phase(32'd1000,    40, 1'b1, 1'b0);   // back-to-back on both streams
    run_phase($urandom,    40, 1'b0, 1'b0);
    run_phase(32'd50,      40, 1'b1, 1'b1);   // receiver hold-off

    // sets just below, at and past the buffer depth: index saturates at the top
    wait_idle();
    write_threshold(32'd1000);
    no_idle = 1'b0;
    add_random_set(BufferDepth);
    add_random_set(BufferDepth + 6);
    add_random_set(BufferDepth - 1);

    run_phase(ThrReset,    40, 1'b0, 1'b0);
    wait_idle();

    $display("Run covered %0d requests and %0d winners, sets of 1 to %0d requests,",
             requests_seen, winners_seen, longest_set);
    $display("thresholds from 0 to all ones, random gaps and one long output stall.");
    if (errors == 0 && winner_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
